>>> hw/rtl/bmp_rgb_to_gray_stream_unit_defines.svh
// Assertion macros shared by the bmpgray RTL.
// Each expects signals clk and rst_n in the scope of use.
`ifndef BMP_RGB_TO_GRAY_STREAM_UNIT_DEFINES_SVH
`define BMP_RGB_TO_GRAY_STREAM_UNIT_DEFINES_SVH

// Condition holds at every clock outside reset.
`define BMPGRAY_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bmpgray assertion failed");

// Antecedent implies consequent in the same cycle.
`define BMPGRAY_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmpgray assertion failed");

// Antecedent implies consequent in the next cycle.
`define BMPGRAY_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmpgray assertion failed");

`endif

>>> hw/rtl/bmpgray_pkg.sv
// Shared types and constants for the bitmap-to-gray stream unit.
// No dependencies.
`default_nettype none
package bmpgray_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int BYTE_W    = 8;
    localparam int IMG_W_W   = 13;
    localparam int HEIGHT_W  = 14;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W = 1;
    localparam int GRAY_W    = 16;
    localparam int POS_W     = 12;
    localparam int PROD_W    = 24;
    localparam int SUM_W     = 25;

    localparam logic [15:0] WEIGHT_FIRST  = 16'd19589;
    localparam logic [15:0] WEIGHT_SECOND = 16'd38470;
    localparam logic [15:0] WEIGHT_THIRD  = 16'd7471;
    localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(128);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    // One complete pixel headed for the back end.
    typedef struct packed {
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } pix_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/bmpgray_front.sv
// Front end: byte accept, pixel assembly, padding skip, row/column tracking.
// Depends on bmpgray_pkg and the defines header.
`default_nettype none
`include "bmp_rgb_to_gray_stream_unit_defines.svh"
module bmpgray_front #(
    parameter int MAX_WIDTH  = bmpgray_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpgray_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [bmpgray_pkg::IMG_W_W-1:0]   image_width,
    input  wire logic signed [bmpgray_pkg::HEIGHT_W-1:0] signed_height,
    input  wire logic                              in_valid,
    output      logic                              in_ready,
    input  wire logic [bmpgray_pkg::BYTE_W-1:0]    pixel_byte,
    input  wire logic                              last_byte,
    input  wire bmpgray_pkg::q_status_t            q_status,
    output      logic                              q_push,
    output      bmpgray_pkg::pix_t                 q_data
);
    import bmpgray_pkg::*;

    localparam int EffWMax = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
    localparam int EffHMax = (MAX_HEIGHT < 8192) ? MAX_HEIGHT : 8192;
    localparam int CW = $clog2(EffWMax + 1);
    localparam int RW = $clog2(EffHMax + 1);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] first_reg, first_next;
    logic [BYTE_W-1:0] second_reg, second_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [1:0]        pad_reg, pad_next;

    logic [CW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] h_abs;
    logic [RW-1:0]       eff_h;
    logic [RW-1:0]       row_dest;
    logic                acc;
    logic                is_third;
    logic                emit_ok;
    logic                row_end;

    always_comb
    begin
        eff_w = (image_width > IMG_W_W'(EffWMax)) ? CW'(EffWMax) : CW'(image_width);
        h_abs = signed_height[HEIGHT_W-1] ? (~signed_height + 1'b1) : signed_height;
        eff_h = (h_abs > HEIGHT_W'(EffHMax)) ? RW'(EffHMax) : RW'(h_abs);
    end

    assign in_ready = !q_status.full;
    assign acc      = in_valid && in_ready;
    assign is_third = (pad_reg == 2'd0) && (phase_reg == PH_THIRD);
    assign emit_ok  = (eff_w != '0) && (eff_h != '0) && (row_reg < eff_h);
    assign row_end  = ({1'b0, col_reg} + 1'b1) >= {1'b0, eff_w};
    assign row_dest = signed_height[HEIGHT_W-1] ? row_reg : (eff_h - 1'b1 - row_reg);

    assign q_push     = acc && is_third && emit_ok;
    assign q_data.b0  = first_reg;
    assign q_data.b1  = second_reg;
    assign q_data.b2  = pixel_byte;
    assign q_data.row = POS_W'(row_dest);
    assign q_data.col = POS_W'(col_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pad_next    = pad_reg;
        if (acc)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        first_next = pixel_byte;
                        phase_next = PH_SECOND;
                    end
                    PH_SECOND:
                    begin
                        second_next = pixel_byte;
                        phase_next  = PH_THIRD;
                    end
                    PH_THIRD:
                    begin
                        phase_next = PH_FIRST;
                        if (eff_w != '0)
                        begin
                            if (row_end)
                            begin
                                col_next = '0;
                                if (row_reg < eff_h)
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                                // 3*w padded to 4 bytes: pad equals w mod 4
                                pad_next = eff_w[1:0];
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_FIRST;
                    end
                endcase
            end
            if (last_byte)
            begin
                phase_next  = PH_FIRST;
                first_next  = '0;
                second_next = '0;
                col_next    = '0;
                row_next    = '0;
                pad_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            first_reg  <= '0;
            second_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            pad_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pad_reg    <= pad_next;
        end
    end

    `BMPGRAY_ASSERT_SAME(a_pad_at_pixel_start, pad_reg != 2'd0, phase_reg == PH_FIRST)
    `BMPGRAY_ASSERT_ALWAYS(a_row_saturates, row_reg <= RW'(EffHMax))

endmodule
`default_nettype wire

>>> hw/rtl/bmpgray_queue.sv
// Four-entry pixel queue between front and back ends.
// Depends on bmpgray_pkg and the defines header.
`default_nettype none
`include "bmp_rgb_to_gray_stream_unit_defines.svh"
module bmpgray_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire bmpgray_pkg::pix_t       push_data,
    input  wire logic                    pop,
    output      bmpgray_pkg::pix_t       pop_data,
    output      bmpgray_pkg::q_status_t  status
);
    import bmpgray_pkg::*;

    localparam int Depth = 4;
    localparam int PW    = $clog2(Depth);

    pix_t          mem_reg [Depth];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign status.full  = (count_reg == (PW+1)'(Depth));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BMPGRAY_ASSERT_SAME(a_no_push_full, push, !status.full)
    `BMPGRAY_ASSERT_ALWAYS(a_ptr_count, PW'(wr_ptr_reg - rd_ptr_reg) == count_reg[PW-1:0])

endmodule
`default_nettype wire

>>> hw/rtl/bmpgray_back.sv
// Back end: weighted-sum pipeline (products, then sum and rounding) and output register.
// Depends on bmpgray_pkg and the defines header.
`default_nettype none
`include "bmp_rgb_to_gray_stream_unit_defines.svh"
module bmpgray_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire bmpgray_pkg::q_status_t           q_status,
    input  wire bmpgray_pkg::pix_t                q_data,
    output      logic                             q_pop,
    output      logic                             out_valid,
    input  wire logic                             out_ready,
    output      logic [bmpgray_pkg::GRAY_W-1:0]   gray_level,
    output      logic [bmpgray_pkg::POS_W-1:0]    row_index,
    output      logic [bmpgray_pkg::POS_W-1:0]    column_index
);
    import bmpgray_pkg::*;

    logic              s1_v_reg, s1_v_next;
    logic [PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic [POS_W-1:0]  s1_row_reg, s1_col_reg;
    logic              out_v_reg, out_v_next;
    logic [GRAY_W-1:0] gray_reg;
    logic [POS_W-1:0]  row_reg, col_reg;
    logic              out_en;
    logic              s1_en;
    logic [SUM_W-1:0]  sum;

    assign out_en = !out_v_reg || out_ready;
    assign s1_en  = !s1_v_reg || out_en;
    assign q_pop  = s1_en && !q_status.empty;

    assign sum = SUM_W'(p0_reg) + SUM_W'(p1_reg) + SUM_W'(p2_reg) + ROUND_BIAS;

    always_comb
    begin
        s1_v_next  = s1_en ? !q_status.empty : s1_v_reg;
        out_v_next = out_en ? s1_v_reg : out_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            p0_reg     <= q_data.b0 * WEIGHT_FIRST;
            p1_reg     <= q_data.b1 * WEIGHT_SECOND;
            p2_reg     <= q_data.b2 * WEIGHT_THIRD;
            s1_row_reg <= q_data.row;
            s1_col_reg <= q_data.col;
        end
        if (out_en)
        begin
            gray_reg <= sum[GRAY_W+7:8];
            row_reg  <= s1_row_reg;
            col_reg  <= s1_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            out_v_reg <= out_v_next;
        end
    end

    assign out_valid    = out_v_reg;
    assign gray_level   = gray_reg;
    assign row_index    = row_reg;
    assign column_index = col_reg;

    `BMPGRAY_ASSERT_NEXT(a_s1_held, s1_v_reg && !s1_en, s1_v_reg)

endmodule
`default_nettype wire

>>> hw/rtl/bmp_rgb_to_gray_stream_unit.sv
// Bitmap byte stream to gray levels, one byte accepted per cycle when not back-pressured.
// A pixel is written to the queue with its third byte, then to the product register, then to the output register.
// Throughput: 1 byte per cycle when not back-pressured, set by the 4-entry queue and the 2-stage sum pipeline.
// Reset: asynchronous, active low; clears counters, queue and valids, loads
// image_width 640 and signed_height 480. Depends on bmpgray_pkg and the sub-modules.
`default_nettype none
module bmp_rgb_to_gray_stream_unit #(
    parameter int MAX_WIDTH  = bmpgray_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpgray_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [bmpgray_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bmpgray_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                                in_valid,
    output      logic                                in_ready,
    input  wire logic [bmpgray_pkg::BYTE_W-1:0]      pixel_byte,
    input  wire logic                                last_byte,
    output      logic                                out_valid,
    input  wire logic                                out_ready,
    output      logic [bmpgray_pkg::GRAY_W-1:0]      gray_level,
    output      logic [bmpgray_pkg::POS_W-1:0]       row_index,
    output      logic [bmpgray_pkg::POS_W-1:0]       column_index
);
    import bmpgray_pkg::*;

    logic [IMG_W_W-1:0]         width_reg;
    logic signed [HEIGHT_W-1:0] height_reg;
    q_status_t                  q_status;
    logic                       q_push;
    logic                       q_pop;
    pix_t                       q_in;
    pix_t                       q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMG_W_W'(640);
            height_reg <= HEIGHT_W'(480);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[IMG_W_W-1:0];
                CFG_SIGNED_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    bmpgray_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .image_width   (width_reg),
        .signed_height (height_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_byte    (pixel_byte),
        .last_byte     (last_byte),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    bmpgray_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .status    (q_status)
    );

    bmpgray_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .gray_level   (gray_level),
        .row_index    (row_index),
        .column_index (column_index)
    );

endmodule
`default_nettype wire
